@@ src/pet_pkg.sv @@
// Package for the periodic event ticker: field widths, command and register codes,
// controller states and the record types of the slot table and the slot state memory.
// No dependencies.
`default_nettype none
package pet_pkg;

    localparam int unsigned TICK_W  = 32;
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned PRIO_W  = 3;
    localparam int unsigned SPACE_W = 6;
    localparam int unsigned ACT_W   = 4;
    localparam int unsigned SEL_W   = 3;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned WIDE_W  = 7;

    localparam logic [SPACE_W-1:0] EVENT_CAP = 6'd32;

    localparam logic [KIND_W-1:0] KIND_POLL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_ACTIVE = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_SELECT = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_PERIOD = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_EVENT  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_PRIO   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_RD,
        ST_P_LOAD,
        ST_P_LOOP,
        ST_P_LAG,
        ST_P_WB,
        ST_C_RD,
        ST_C_EVAL,
        ST_A_RD,
        ST_A_WR,
        ST_Q_RD,
        ST_SUMMARY
    } t_eng_state;

    typedef struct packed {
        logic [TICK_W-1:0] period;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
    } t_tbl_rec;

    typedef struct packed {
        logic [TICK_W-1:0] due;
        logic [TICK_W-1:0] drop;
    } t_slot_rec;

endpackage
`default_nettype wire

@@ src/pet_slot_table.sv @@
// Configuration registers and the slot table memory (period, event code, priority).
// Depends on pet_pkg.
`default_nettype none
module pet_slot_table #(
    parameter int unsigned SLOT_COUNT_MAX = 8,
    parameter int unsigned SW = 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [pet_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  wire logic [pet_pkg::TICK_W-1:0]   i_cfg_data,
    input  wire logic [SW-1:0]                i_rd_addr,
    output pet_pkg::t_tbl_rec                 o_rd_data,
    output logic [pet_pkg::ACT_W-1:0]         o_active_slots
);

    logic [pet_pkg::TICK_W-1:0] r_period_mem [SLOT_COUNT_MAX];
    logic [pet_pkg::CODE_W-1:0] r_code_mem [SLOT_COUNT_MAX];
    logic [pet_pkg::PRIO_W-1:0] r_prio_mem [SLOT_COUNT_MAX];

    logic [pet_pkg::ACT_W-1:0]  r_active;
    logic [pet_pkg::SEL_W-1:0]  r_select;
    pet_pkg::t_tbl_rec          r_rd;
    logic [pet_pkg::WIDE_W-1:0] sel_ext;
    logic [SW-1:0]              wr_addr;
    logic                       sel_ok;

    assign sel_ext = {{(pet_pkg::WIDE_W - pet_pkg::SEL_W){1'b0}}, r_select};
    assign wr_addr = sel_ext[SW-1:0];
    assign sel_ok  = sel_ext < pet_pkg::WIDE_W'(SLOT_COUNT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_select <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pet_pkg::CFG_ACTIVE: begin
                    r_active <= i_cfg_data[pet_pkg::ACT_W-1:0];
                end
                pet_pkg::CFG_SELECT: begin
                    r_select <= i_cfg_data[pet_pkg::SEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_we && sel_ok) begin
            case (i_cfg_idx)
                pet_pkg::CFG_PERIOD: begin
                    r_period_mem[wr_addr] <= i_cfg_data;
                end
                pet_pkg::CFG_EVENT: begin
                    r_code_mem[wr_addr] <= i_cfg_data[pet_pkg::CODE_W-1:0];
                end
                pet_pkg::CFG_PRIO: begin
                    r_prio_mem[wr_addr] <= i_cfg_data[pet_pkg::PRIO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd.period <= r_period_mem[i_rd_addr];
        r_rd.code   <= r_code_mem[i_rd_addr];
        r_rd.prio   <= r_prio_mem[i_rd_addr];
    end

    assign o_rd_data      = r_rd;
    assign o_active_slots = r_active;

endmodule
`default_nettype wire

@@ src/pet_state_mem.sv @@
// Slot state memory holding the due tick and the drop counter of every slot.
// One write port, one read port with registered read data. Depends on pet_pkg.
`default_nettype none
module pet_state_mem #(
    parameter int unsigned SLOT_COUNT_MAX = 8,
    parameter int unsigned SW = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [SW-1:0]      i_wr_addr,
    input  wire pet_pkg::t_slot_rec i_wr_data,
    input  wire logic [SW-1:0]      i_rd_addr,
    output pet_pkg::t_slot_rec      o_rd_data
);

    pet_pkg::t_slot_rec r_mem [SLOT_COUNT_MAX];
    pet_pkg::t_slot_rec r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule
`default_nettype wire

@@ src/pet_engine.sv @@
// Command sequencer: start validation and arming, poll walk with catch-up, clear, summary.
// Reads and writes back the slot state memory, reads the slot table. Depends on pet_pkg.
`default_nettype none
module pet_engine #(
    parameter int unsigned SLOT_COUNT_MAX = 8,
    parameter int unsigned CATCHUP_LIMIT = 4,
    parameter int unsigned SW = 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [pet_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [pet_pkg::TICK_W-1:0]    i_now_tick,
    input  wire logic [pet_pkg::SPACE_W-1:0]   i_bus_space,
    input  wire logic [pet_pkg::SLOT_W-1:0]    i_query_slot,
    input  wire logic [pet_pkg::ACT_W-1:0]     i_active_slots,
    output logic [SW-1:0]                      o_rd_addr,
    input  wire pet_pkg::t_tbl_rec             i_tbl_rd,
    input  wire pet_pkg::t_slot_rec            i_st_rd,
    output logic                               o_st_wr_en,
    output logic [SW-1:0]                      o_st_wr_addr,
    output pet_pkg::t_slot_rec                 o_st_wr_data,
    output logic                               o_valid,
    output logic                               o_is_event,
    output logic [pet_pkg::SLOT_W-1:0]         o_source_slot,
    output logic [pet_pkg::CODE_W-1:0]         o_event_code,
    output logic [pet_pkg::PRIO_W-1:0]         o_event_priority,
    output logic [pet_pkg::SPACE_W-1:0]        o_published_count,
    output logic                               o_status,
    output logic [pet_pkg::TICK_W-1:0]         o_drop_count,
    output logic                               o_last
);

    localparam int unsigned NW = $clog2(CATCHUP_LIMIT + 1);
    localparam int unsigned AW = pet_pkg::ACT_W;
    localparam int unsigned TW = pet_pkg::TICK_W;

    pet_pkg::t_eng_state r_state, n_state;

    logic [TW-1:0]                  r_now, n_now;
    logic [pet_pkg::SPACE_W-1:0]    r_space, n_space;
    logic [pet_pkg::SLOT_W-1:0]     r_q, n_q;
    logic                           r_qhit, n_qhit;
    logic [pet_pkg::SPACE_W-1:0]    r_pub, n_pub;
    logic                           r_status, n_status;
    logic [AW-1:0]                  r_idx, n_idx;
    logic [AW-1:0]                  r_armed, n_armed;
    logic                           r_started, n_started;
    logic [TW-1:0]                  r_due, n_due;
    logic [TW-1:0]                  r_drop, n_drop;
    logic [TW-1:0]                  r_period, n_period;
    logic [pet_pkg::CODE_W-1:0]     r_code, n_code;
    logic [pet_pkg::PRIO_W-1:0]     r_prio, n_prio;
    logic [NW-1:0]                  r_n, n_n;

    logic                           r_o_valid, n_o_valid;
    logic                           r_o_is_event, n_o_is_event;
    logic [pet_pkg::SLOT_W-1:0]     r_o_slot, n_o_slot;
    logic [pet_pkg::CODE_W-1:0]     r_o_code, n_o_code;
    logic [pet_pkg::PRIO_W-1:0]     r_o_prio, n_o_prio;
    logic [pet_pkg::SPACE_W-1:0]    r_o_pub, n_o_pub;
    logic                           r_o_status, n_o_status;
    logic [TW-1:0]                  r_o_drop, n_o_drop;
    logic                           r_o_last, n_o_last;

    logic [TW-1:0]                  lag;
    logic                           due_now;
    logic                           space_ok;
    logic                           lag_over;
    logic [AW-1:0]                  idx_inc;
    logic                           poll_last;
    logic                           start_last;
    logic                           too_many;
    logic [pet_pkg::WIDE_W-1:0]     idx_ext;
    logic [pet_pkg::WIDE_W-1:0]     q_ext;
    logic [pet_pkg::SPACE_W-1:0]    space_clamp;

    assign lag         = r_now - r_due;
    assign due_now     = !lag[TW-1] && (r_n < NW'(CATCHUP_LIMIT));
    assign space_ok    = r_pub < r_space;
    assign lag_over    = lag >= r_period;
    assign idx_inc     = r_idx + AW'(1);
    assign poll_last   = idx_inc == r_armed;
    assign start_last  = idx_inc == i_active_slots;
    assign too_many    = {{(pet_pkg::WIDE_W - AW){1'b0}}, i_active_slots}
                         > pet_pkg::WIDE_W'(SLOT_COUNT_MAX);
    assign idx_ext     = {{(pet_pkg::WIDE_W - AW){1'b0}}, r_idx};
    assign q_ext       = {{(pet_pkg::WIDE_W - pet_pkg::SLOT_W){1'b0}}, r_q};
    assign space_clamp = (i_bus_space > pet_pkg::EVENT_CAP) ? pet_pkg::EVENT_CAP : i_bus_space;

    assign o_busy = r_state != pet_pkg::ST_IDLE;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pet_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_kind)
                        pet_pkg::KIND_POLL: begin
                            if (!r_started) begin
                                n_state = pet_pkg::ST_SUMMARY;
                            end else if (r_armed == '0) begin
                                n_state = pet_pkg::ST_Q_RD;
                            end else begin
                                n_state = pet_pkg::ST_P_RD;
                            end
                        end
                        pet_pkg::KIND_START: begin
                            if (too_many) begin
                                n_state = pet_pkg::ST_Q_RD;
                            end else if (i_active_slots == '0) begin
                                n_state = pet_pkg::ST_Q_RD;
                            end else begin
                                n_state = pet_pkg::ST_C_RD;
                            end
                        end
                        default: begin
                            n_state = pet_pkg::ST_Q_RD;
                        end
                    endcase
                end
            end
            pet_pkg::ST_P_RD: begin
                n_state = pet_pkg::ST_P_LOAD;
            end
            pet_pkg::ST_P_LOAD: begin
                n_state = pet_pkg::ST_P_LOOP;
            end
            pet_pkg::ST_P_LOOP: begin
                if (due_now && space_ok) begin
                    n_state = pet_pkg::ST_P_LAG;
                end else begin
                    n_state = pet_pkg::ST_P_WB;
                end
            end
            pet_pkg::ST_P_LAG: begin
                n_state = lag_over ? pet_pkg::ST_P_WB : pet_pkg::ST_P_LOOP;
            end
            pet_pkg::ST_P_WB: begin
                n_state = poll_last ? pet_pkg::ST_Q_RD : pet_pkg::ST_P_RD;
            end
            pet_pkg::ST_C_RD: begin
                n_state = pet_pkg::ST_C_EVAL;
            end
            pet_pkg::ST_C_EVAL: begin
                if (i_tbl_rd.period == '0) begin
                    n_state = pet_pkg::ST_Q_RD;
                end else if (start_last) begin
                    n_state = pet_pkg::ST_A_RD;
                end else begin
                    n_state = pet_pkg::ST_C_RD;
                end
            end
            pet_pkg::ST_A_RD: begin
                n_state = pet_pkg::ST_A_WR;
            end
            pet_pkg::ST_A_WR: begin
                n_state = start_last ? pet_pkg::ST_Q_RD : pet_pkg::ST_A_RD;
            end
            pet_pkg::ST_Q_RD: begin
                n_state = pet_pkg::ST_SUMMARY;
            end
            pet_pkg::ST_SUMMARY: begin
                n_state = pet_pkg::ST_IDLE;
            end
            default: begin
                n_state = pet_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_now        = r_now;
        n_space      = r_space;
        n_q          = r_q;
        n_qhit       = r_qhit;
        n_pub        = r_pub;
        n_status     = r_status;
        n_idx        = r_idx;
        n_armed      = r_armed;
        n_started    = r_started;
        n_due        = r_due;
        n_drop       = r_drop;
        n_period     = r_period;
        n_code       = r_code;
        n_prio       = r_prio;
        n_n          = r_n;
        n_o_valid    = 1'b0;
        n_o_is_event = 1'b0;
        n_o_slot     = '0;
        n_o_code     = '0;
        n_o_prio     = '0;
        n_o_pub      = '0;
        n_o_status   = 1'b0;
        n_o_drop     = '0;
        n_o_last     = 1'b0;
        o_rd_addr    = idx_ext[SW-1:0];
        o_st_wr_en   = 1'b0;
        o_st_wr_addr = idx_ext[SW-1:0];
        o_st_wr_data = '{due: r_due, drop: r_drop};
        case (r_state)
            pet_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_now    = i_now_tick;
                    n_space  = space_clamp;
                    n_q      = i_query_slot;
                    n_pub    = '0;
                    n_status = 1'b0;
                    n_idx    = '0;
                    case (i_kind)
                        pet_pkg::KIND_POLL: begin
                            n_status = !r_started;
                        end
                        pet_pkg::KIND_START: begin
                            if (too_many) begin
                                n_status = 1'b1;
                            end else if (i_active_slots == '0) begin
                                n_armed   = '0;
                                n_started = 1'b1;
                            end
                        end
                        pet_pkg::KIND_CLEAR: begin
                            n_armed   = '0;
                            n_started = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pet_pkg::ST_P_LOAD: begin
                n_due    = i_st_rd.due;
                n_drop   = i_st_rd.drop;
                n_period = i_tbl_rd.period;
                n_code   = i_tbl_rd.code;
                n_prio   = i_tbl_rd.prio;
                n_n      = '0;
            end
            pet_pkg::ST_P_LOOP: begin
                if (due_now) begin
                    if (!space_ok) begin
                        n_drop = r_drop + TW'(1);
                    end else begin
                        n_o_valid    = 1'b1;
                        n_o_is_event = 1'b1;
                        n_o_slot     = idx_ext[pet_pkg::SLOT_W-1:0];
                        n_o_code     = r_code;
                        n_o_prio     = r_prio;
                        n_pub        = r_pub + pet_pkg::SPACE_W'(1);
                        n_n          = r_n + NW'(1);
                        n_due        = r_due + r_period;
                    end
                end
            end
            pet_pkg::ST_P_LAG: begin
                if (lag_over) begin
                    n_due = r_now + r_period;
                end
            end
            pet_pkg::ST_P_WB: begin
                o_st_wr_en = 1'b1;
                n_idx      = idx_inc;
            end
            pet_pkg::ST_C_EVAL: begin
                if (i_tbl_rd.period == '0) begin
                    n_status = 1'b1;
                end else if (start_last) begin
                    n_idx = '0;
                end else begin
                    n_idx = idx_inc;
                end
            end
            pet_pkg::ST_A_WR: begin
                o_st_wr_en   = 1'b1;
                o_st_wr_data = '{due: r_now + i_tbl_rd.period, drop: '0};
                n_idx        = idx_inc;
                if (start_last) begin
                    n_armed   = i_active_slots;
                    n_started = 1'b1;
                end
            end
            pet_pkg::ST_Q_RD: begin
                o_rd_addr = q_ext[SW-1:0];
                n_qhit    = {1'b0, r_q} < r_armed;
            end
            pet_pkg::ST_SUMMARY: begin
                n_o_valid  = 1'b1;
                n_o_pub    = r_pub;
                n_o_status = r_status;
                n_o_drop   = r_qhit ? i_st_rd.drop : '0;
                n_o_last   = 1'b1;
                n_qhit     = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pet_pkg::ST_IDLE;
            r_armed   <= '0;
            r_started <= 1'b0;
            r_qhit    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_armed   <= n_armed;
            r_started <= n_started;
            r_qhit    <= n_qhit;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now        <= n_now;
        r_space      <= n_space;
        r_q          <= n_q;
        r_pub        <= n_pub;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_due        <= n_due;
        r_drop       <= n_drop;
        r_period     <= n_period;
        r_code       <= n_code;
        r_prio       <= n_prio;
        r_n          <= n_n;
        r_o_is_event <= n_o_is_event;
        r_o_slot     <= n_o_slot;
        r_o_code     <= n_o_code;
        r_o_prio     <= n_o_prio;
        r_o_pub      <= n_o_pub;
        r_o_status   <= n_o_status;
        r_o_drop     <= n_o_drop;
        r_o_last     <= n_o_last;
    end

    assign o_valid           = r_o_valid;
    assign o_is_event        = r_o_is_event;
    assign o_source_slot     = r_o_slot;
    assign o_event_code      = r_o_code;
    assign o_event_priority  = r_o_prio;
    assign o_published_count = r_o_pub;
    assign o_status          = r_o_status;
    assign o_drop_count      = r_o_drop;
    assign o_last            = r_o_last;

endmodule
`default_nettype wire

@@ src/periodic_event_ticker_unit.sv @@
// Top level of the periodic event ticker: slot table, slot state memory, sequencer.
// From accept to summary beat: a poll reads each armed slot, emits its due events up to the
// catch-up limit while bus space lasts and writes the slot back; a start checks every active
// period, then arms each slot; a clear, or a poll while not started, goes on to the summary.
// No new command is taken before the summary, the receiver cannot stall, and each beat is on
// the outputs for one cycle. Synchronous active-low reset clears state, started, armed, valid.
`default_nettype none
module periodic_event_ticker_unit #(
    parameter int unsigned SLOT_COUNT_MAX = 8,
    parameter int unsigned CATCHUP_LIMIT = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pet_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [pet_pkg::TICK_W-1:0]    i_now_tick,
    input  wire logic [pet_pkg::SPACE_W-1:0]   i_bus_space,
    input  wire logic [pet_pkg::SLOT_W-1:0]    i_query_slot,
    input  wire logic                          i_cfg_we,
    input  wire logic [pet_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  wire logic [pet_pkg::TICK_W-1:0]    i_cfg_data,
    output logic                               o_valid,
    output logic                               o_is_event,
    output logic [pet_pkg::SLOT_W-1:0]         o_source_slot,
    output logic [pet_pkg::CODE_W-1:0]         o_event_code,
    output logic [pet_pkg::PRIO_W-1:0]         o_event_priority,
    output logic [pet_pkg::SPACE_W-1:0]        o_published_count,
    output logic                               o_status,
    output logic [pet_pkg::TICK_W-1:0]         o_drop_count,
    output logic                               o_last
);

    localparam int unsigned SW = (SLOT_COUNT_MAX > 1) ? $clog2(SLOT_COUNT_MAX) : 1;

    logic [SW-1:0]                 rd_addr;
    pet_pkg::t_tbl_rec             tbl_rd;
    pet_pkg::t_slot_rec            st_rd;
    logic                          st_wr_en;
    logic [SW-1:0]                 st_wr_addr;
    pet_pkg::t_slot_rec            st_wr_data;
    logic [pet_pkg::ACT_W-1:0]     active_slots;

    pet_slot_table #(
        .SLOT_COUNT_MAX (SLOT_COUNT_MAX),
        .SW             (SW)
    ) u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_rd_addr      (rd_addr),
        .o_rd_data      (tbl_rd),
        .o_active_slots (active_slots)
    );

    pet_state_mem #(
        .SLOT_COUNT_MAX (SLOT_COUNT_MAX),
        .SW             (SW)
    ) u_state (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (st_rd)
    );

    pet_engine #(
        .SLOT_COUNT_MAX (SLOT_COUNT_MAX),
        .CATCHUP_LIMIT  (CATCHUP_LIMIT),
        .SW             (SW)
    ) u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_kind            (i_kind),
        .i_now_tick        (i_now_tick),
        .i_bus_space       (i_bus_space),
        .i_query_slot      (i_query_slot),
        .i_active_slots    (active_slots),
        .o_rd_addr         (rd_addr),
        .i_tbl_rd          (tbl_rd),
        .i_st_rd           (st_rd),
        .o_st_wr_en        (st_wr_en),
        .o_st_wr_addr      (st_wr_addr),
        .o_st_wr_data      (st_wr_data),
        .o_valid           (o_valid),
        .o_is_event        (o_is_event),
        .o_source_slot     (o_source_slot),
        .o_event_code      (o_event_code),
        .o_event_priority  (o_event_priority),
        .o_published_count (o_published_count),
        .o_status          (o_status),
        .o_drop_count      (o_drop_count),
        .o_last            (o_last)
    );

endmodule
`default_nettype wire
